@@ rtl/bmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

   // Frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W = 8;
   localparam int CFG_W = 11;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int SZ_A  = (CFG_W > WID_W) ? CFG_W : WID_W;
   localparam int SZ_W  = (SZ_A > ROW_W) ? SZ_A : ROW_W;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_MODE   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH  = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT = CSR_ADDR_W'(2);

   localparam logic MODE_DILATE = 1'b0;
   localparam logic MODE_ERODE  = 1'b1;

   localparam logic [PIX_W-1:0] FULL_VALUE   = 8'd255;
   localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

   // One item held between the memory read and the evaluation
   typedef struct packed {
      logic             mode;
      logic             emit;        // item produces a result
      logic             upd_upper;   // shift middle row into upper row
      logic             has_left;
      logic             last_col;
      logic             has_up;
      logic             drain;
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
      logic             fwd_up;
      logic             fwd_mid;
      logic             fwd_right;
      logic [PIX_W-1:0] fwd_up_data;
      logic [PIX_W-1:0] fwd_mid_data;
   } stage_type;

   // Row store write port
   typedef struct packed {
      logic             mid_en;
      logic             up_en;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] mid_data;
      logic [PIX_W-1:0] up_data;
   } wr_type;

   function automatic logic [SZ_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [SZ_W-1:0]  maxv);
      logic [SZ_W-1:0] ve;
      ve = SZ_W'(v);
      if (ve < SZ_W'(2)) begin
         return SZ_W'(2);
      end else if (ve > maxv) begin
         return maxv;
      end
      return ve;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bmc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/bmc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [bmc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [bmc_pkg::CFG_W-1:0]        csr_wdata,
   input  wire logic                             req_tvalid,
   input  wire logic [bmc_pkg::PIX_W-1:0]        req_tdata,
   input  wire logic                             req_tuser,
   output logic                                  req_tready,
   input  wire logic                             b_go,
   input  wire bmc_pkg::wr_type                  wr,
   output logic                                  rd_en,
   output logic      [bmc_pkg::COL_W-1:0]        rd_addr_cur,
   output logic      [bmc_pkg::COL_W-1:0]        rd_addr_next,
   output logic                                  b_valid,
   output bmc_pkg::stage_type                    stage
);

   logic                        mode_ff, mode_in;
   logic [bmc_pkg::CFG_W-1:0]   width_ff, width_in;
   logic [bmc_pkg::CFG_W-1:0]   height_ff, height_in;
   logic [bmc_pkg::COL_W-1:0]   col_ff, col_in;
   logic [bmc_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                        b_valid_ff, b_valid_in;
   bmc_pkg::stage_type          stage_ff, stage_in;

   logic [bmc_pkg::SZ_W-1:0]    w, h, col_ext, col_inc, row_ext;
   logic                        drain, last_col, stray, accept, load;
   logic [bmc_pkg::PIX_W-1:0]   pix;

   always_comb begin
      w       = bmc_pkg::clamp_size(width_ff, bmc_pkg::SZ_W'(bmc_pkg::MAX_WIDTH));
      h       = bmc_pkg::clamp_size(height_ff, bmc_pkg::SZ_W'(bmc_pkg::MAX_HEIGHT));
      col_ext = bmc_pkg::SZ_W'(col_ff);
      col_inc = col_ext + bmc_pkg::SZ_W'(1);
      row_ext = bmc_pkg::SZ_W'(row_ff);
      drain    = (row_ext >= h);
      last_col = (col_inc >= w);
      stray    = !drain && req_tuser;
      pix      = drain ? '0 : req_tdata;

      req_tready = !b_valid_ff || b_go;
      accept     = req_tvalid && req_tready;
      load       = accept && !stray;

      rd_en        = load;
      rd_addr_cur  = col_ff;
      rd_addr_next = bmc_pkg::COL_W'(col_inc);

      col_in = col_ff;
      row_in = row_ff;
      if (load) begin
         if (last_col) begin
            col_in = '0;
            row_in = drain ? '0 : (row_ff + bmc_pkg::ROW_W'(1));
         end else begin
            col_in = bmc_pkg::COL_W'(col_inc);
         end
      end

      b_valid_in = load ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);

      stage_in = stage_ff;
      if (load) begin
         stage_in.mode      = mode_ff;
         stage_in.emit      = (row_ff != '0);
         stage_in.upd_upper = (row_ff != '0);
         stage_in.has_left  = (col_ff != '0);
         stage_in.last_col  = last_col;
         // output row is height-1 in the drain phase, else row-1
         stage_in.has_up    = drain || (row_ext >= bmc_pkg::SZ_W'(2));
         stage_in.drain     = drain;
         stage_in.pix       = pix;
         stage_in.col       = col_ff;
         // the item leaving the eval stage writes the stores in this cycle
         stage_in.fwd_up    = wr.up_en && (wr.addr == rd_addr_cur);
         stage_in.fwd_mid   = wr.mid_en && (wr.addr == rd_addr_cur);
         stage_in.fwd_right = wr.mid_en && (wr.addr == rd_addr_next);
         stage_in.fwd_up_data  = wr.up_data;
         stage_in.fwd_mid_data = wr.mid_data;
      end

      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            bmc_pkg::REG_MODE:   mode_in   = csr_wdata[0];
            bmc_pkg::REG_WIDTH:  width_in  = csr_wdata;
            bmc_pkg::REG_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= bmc_pkg::MODE_DILATE;
         width_ff   <= bmc_pkg::RESET_WIDTH;
         height_ff  <= bmc_pkg::RESET_HEIGHT;
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= b_valid_in;
      end
      stage_ff <= stage_in;
   end

   assign b_valid = b_valid_ff;
   assign stage   = stage_ff;

endmodule

`default_nettype wire

@@ rtl/bmc_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_eval (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        b_valid,
   input  wire bmc_pkg::stage_type          stage,
   input  wire logic [bmc_pkg::PIX_W-1:0]   up_q,
   input  wire logic [bmc_pkg::PIX_W-1:0]   mid_q,
   input  wire logic [bmc_pkg::PIX_W-1:0]   right_q,
   input  wire logic                        rsp_tready,
   output logic                             b_go,
   output bmc_pkg::wr_type                  wr,
   output logic                             rsp_tvalid,
   output logic      [bmc_pkg::PIX_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int SUM_W = bmc_pkg::PIX_W + 2;
   localparam int CNT_W = 3;

   logic [bmc_pkg::PIX_W-1:0] win0_ff, win0_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bmc_pkg::PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [bmc_pkg::PIX_W-1:0] up, mid_cur, right;
   logic [SUM_W-1:0]          sum, full_sum;
   logic [CNT_W-1:0]          cnt;
   logic                      hit, rsp_load;

   always_comb begin
      up      = stage.fwd_up    ? stage.fwd_up_data  : up_q;
      mid_cur = stage.fwd_mid   ? stage.fwd_mid_data : mid_q;
      right   = stage.fwd_right ? stage.fwd_mid_data : right_q;

      sum = '0;
      cnt = '0;
      if (stage.has_left) begin
         sum = sum + SUM_W'(win0_ff);
         cnt = cnt + CNT_W'(1);
      end
      if (!stage.last_col) begin
         sum = sum + SUM_W'(right);
         cnt = cnt + CNT_W'(1);
      end
      if (stage.has_up) begin
         sum = sum + SUM_W'(up);
         cnt = cnt + CNT_W'(1);
      end
      if (!stage.drain) begin
         sum = sum + SUM_W'(stage.pix);
         cnt = cnt + CNT_W'(1);
      end
      full_sum = SUM_W'(SUM_W'(bmc_pkg::FULL_VALUE) * SUM_W'(cnt));

      if (stage.mode == bmc_pkg::MODE_DILATE) begin
         hit = (sum >= SUM_W'(bmc_pkg::FULL_VALUE));
      end else begin
         hit = (sum == full_sum);
      end

      b_go     = b_valid && (!stage.emit || !rsp_valid_ff || rsp_tready);
      rsp_load = b_go && stage.emit;

      wr.mid_en   = b_go;
      wr.up_en    = b_go && stage.upd_upper;
      wr.addr     = stage.col;
      wr.mid_data = stage.pix;
      wr.up_data  = mid_cur;

      win0_in = (b_go && stage.upd_upper) ? mid_cur : win0_ff;

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_data_in = hit ? bmc_pkg::FULL_VALUE : '0;
         rsp_last_in = stage.drain && stage.last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win0_ff      <= win0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/binary_morphology_cross_3x3.sv @@
// Each accepted item is latched, then its result is registered for rsp_tvalid; results
//   trail the input by one frame row (row 0 gives none, the drain items finish the last).
// Throughput: one item per cycle if unstalled, set by the single read/write row store pass.
// Reset (synchronous, active high): counters, neighbour window and handshake state clear,
//   registers return to dilation, 640 x 480. Row stores have no reset and no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module binary_morphology_cross_3x3 (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration write port
   input  wire logic                             csr_we,
   input  wire logic [bmc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [bmc_pkg::CFG_W-1:0]        csr_wdata,
   // input item stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] pixel
   input  wire logic                             req_tuser,   // [0] flush
   // result item stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [7:0]                       rsp_tdata,   // [7:0] result_pixel
   output logic                                  rsp_tlast    // end_of_frame
);

   // Pipeline:
   //   accept  - column/row counters, store reads issued, item latched (bmc_ctrl)
   //   eval    - neighbour sum and compare, store writes, window update (bmc_eval)
   //   output  - result register; the eval stage keeps moving while it is free or drained
   // The item leaving eval writes the stores in the same cycle a new item reads them;
   // a matching address is forwarded so the new item sees the written value.

   bmc_pkg::wr_type              wr;
   bmc_pkg::stage_type           stage;
   logic                         b_go, b_valid, rd_en;
   logic [bmc_pkg::COL_W-1:0]    rd_addr_cur, rd_addr_next;
   logic [bmc_pkg::PIX_W-1:0]    up_q, mid_q, right_q;

   bmc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tready   (req_tready),
      .b_go         (b_go),
      .wr           (wr),
      .rd_en        (rd_en),
      .rd_addr_cur  (rd_addr_cur),
      .rd_addr_next (rd_addr_next),
      .b_valid      (b_valid),
      .stage        (stage)
   );

   // upper row store
   bmc_ram #(.DEPTH(bmc_pkg::MAX_WIDTH), .DATA_W(bmc_pkg::PIX_W)) u_upper (
      .clock   (clock),
      .wr_en   (wr.up_en),
      .wr_addr (wr.addr),
      .wr_data (wr.up_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_cur),
      .rd_data (up_q)
   );

   // middle row store, two copies for the centre and right-hand reads
   bmc_ram #(.DEPTH(bmc_pkg::MAX_WIDTH), .DATA_W(bmc_pkg::PIX_W)) u_mid_cur (
      .clock   (clock),
      .wr_en   (wr.mid_en),
      .wr_addr (wr.addr),
      .wr_data (wr.mid_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_cur),
      .rd_data (mid_q)
   );

   bmc_ram #(.DEPTH(bmc_pkg::MAX_WIDTH), .DATA_W(bmc_pkg::PIX_W)) u_mid_next (
      .clock   (clock),
      .wr_en   (wr.mid_en),
      .wr_addr (wr.addr),
      .wr_data (wr.mid_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_next),
      .rd_data (right_q)
   );

   bmc_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .b_valid    (b_valid),
      .stage      (stage),
      .up_q       (up_q),
      .mid_q      (mid_q),
      .right_q    (right_q),
      .rsp_tready (rsp_tready),
      .b_go       (b_go),
      .wr         (wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/bmc_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_check (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [7:0]                       rsp_tdata,
   input wire logic                             rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // results are binary
   a_rsp_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == 8'd0) || (rsp_tdata == 8'd255))
      else $error("result pixel not 0 or 255");

   // with an empty output register the input side never stalls
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind binary_morphology_cross_3x3 bmc_check u_bmc_check (.*);

`default_nettype wire
